[rtl/ftach_pkg.sv]
// Package with shared types and constants for the fan tachometer speed debouncer.
package ftach_pkg;

  // Field widths.
  localparam int HIGH_W  = 20;
  localparam int RPM_W   = 24;
  localparam int CNT_W   = 5;
  localparam int DRIVE_W = 8;
  localparam int CAP_W   = 2;
  localparam int CFG_IDX_W = 2;

  // The divisor is high_time * 2 * pole count; for a pole count up to 8 it is at most 16 * (2^20 - 1) < 2^24.
  localparam int DIVR_W = 24;
  // The quotient needs as many bits as the dividend.
  localparam int QUO_W  = 26;
  localparam int STEP_W = $clog2(QUO_W);

  // Arithmetic constants.
  localparam logic [QUO_W-1:0] US_PER_MINUTE    = 26'd60000000;
  localparam logic [RPM_W-1:0] NEAR_WINDOW      = 24'd100;
  localparam logic [RPM_W-1:0] ACCEPT_CEILING   = 24'd2000;
  localparam logic [RPM_W-1:0] FALLBACK_CEILING = 24'd2500;
  localparam logic [RPM_W-1:0] RPM_MAX          = 24'hFFFFFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TACH_CAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN1_DRIVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN2_DRIVE = 2'd2;

  // Input transaction payload.
  typedef struct packed {
    logic              fan_index;
    logic [HIGH_W-1:0] high_time_us;
  } in_data_t;

  // Result transaction payload.
  typedef struct packed {
    logic [RPM_W-1:0] rpm_value;
    logic             settled;
  } out_data_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DECIDE
  } ftach_state_t;

endpackage

[rtl/fan_tach_rpm_debouncer_top.sv]
// Top level of the fan tachometer speed debouncer: sequencer, state and output register.
//
// Usage: each input transaction on in_valid/in_stall/in_data carries one
// tachometer sample, the fan index and the measured pulse high time in
// microseconds. The block turns it into a speed with a shared one-bit-per-cycle
// divider, checks it against the stored speed and the attempt counter, and may
// return one result on out_valid/out_stall/out_data (speed and settled flag).
// Many samples give no result while the attempt counter runs up.
// After a measured sample is accepted, the block runs 26 divider steps and a
// decide step before it is back in idle and ready again; the divider loop is
// the longest part. A gated fan or a zero high time skips the divider and goes
// straight to the decide step. A result appears in the output register in the
// cycle after the decision. in_stall is high whenever the sequencer is busy.
// When the receiver stalls, the result holds in the output register; the next
// item may be accepted and divided meanwhile, and a result from it waits until the
// register is free. Reset clears the configuration, the stored speed, the
// attempt count and the output valid flag. Configuration must be written through
// cfg_we/cfg_index/cfg_wdata only while the block is idle; the block does not enforce this.
module fan_tach_rpm_debouncer_top #(
  parameter int POLE_COUNT    = 2,
  parameter int ATTEMPT_LIMIT = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ftach_pkg::in_data_t             in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ftach_pkg::out_data_t            out_data,
  input  logic                            cfg_we,
  input  logic [ftach_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ftach_pkg::DRIVE_W-1:0]   cfg_wdata
);
  import ftach_pkg::*;

  ftach_state_t       state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [DRIVE_W-1:0] drive1_r;
  logic [DRIVE_W-1:0] drive2_r;
  logic [RPM_W-1:0]   last_rpm_r, last_rpm_nxt;
  logic [CNT_W-1:0]   attempt_r, attempt_nxt;
  logic               gated_r, gated_nxt;
  logic               zero_r, zero_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_data_t          out_data_r, out_data_nxt;

  logic               in_accept;
  logic               out_free;
  logic               gated_c;
  logic               div_start;
  logic               div_done;
  logic [DIVR_W-1:0]  divisor_c;
  logic [QUO_W-1:0]   quotient;
  logic [RPM_W-1:0]   speed_c;
  logic [RPM_W-1:0]   diff_c;
  logic               near_c;
  logic [CNT_W-1:0]   cnt_inc_c;
  logic               limit_c;
  logic [RPM_W-1:0]   fallback_c;
  logic               emit_c;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A fan without drive or without a tachometer is not measured.
  assign gated_c = in_data.fan_index ?
                   ((drive2_r == '0) || !cap_r[1]) :
                   ((drive1_r == '0) || !cap_r[0]);

  // Pulse period in microseconds per revolution fraction.
  assign divisor_c = DIVR_W'(DIVR_W'(in_data.high_time_us) * DIVR_W'(2 * POLE_COUNT));

  ftach_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (divisor_c),
    .done     (div_done),
    .quotient (quotient)
  );

  // Decision datapath on the finished quotient.
  always_comb begin
    if (zero_r) begin
      speed_c = '0;
    end else if (quotient[QUO_W-1:RPM_W] != '0) begin
      speed_c = RPM_MAX;
    end else begin
      speed_c = quotient[RPM_W-1:0];
    end
    diff_c     = (last_rpm_r > speed_c) ? (last_rpm_r - speed_c) : (speed_c - last_rpm_r);
    near_c     = (diff_c < NEAR_WINDOW) && (speed_c < ACCEPT_CEILING);
    cnt_inc_c  = attempt_r + 1'b1;
    limit_c    = (cnt_inc_c >= CNT_W'(ATTEMPT_LIMIT));
    fallback_c = (speed_c > FALLBACK_CEILING) ? '0 : speed_c;
    emit_c     = gated_r || near_c || limit_c;
  end

  // Sequencer next state and register updates.
  always_comb begin
    state_nxt     = state_r;
    last_rpm_nxt  = last_rpm_r;
    attempt_nxt   = attempt_r;
    gated_nxt     = gated_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          gated_nxt = gated_c;
          zero_nxt  = (in_data.high_time_us == '0);
          if (gated_c || (in_data.high_time_us == '0)) begin
            state_nxt = ST_DECIDE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!emit_c) begin
          attempt_nxt = cnt_inc_c;
          state_nxt   = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (gated_r) begin
            out_data_nxt.rpm_value = '0;
            out_data_nxt.settled   = 1'b0;
          end else if (near_c) begin
            out_data_nxt.rpm_value = speed_c;
            out_data_nxt.settled   = 1'b1;
            last_rpm_nxt           = speed_c;
            attempt_nxt            = '0;
          end else begin
            out_data_nxt.rpm_value = fallback_c;
            out_data_nxt.settled   = 1'b0;
            last_rpm_nxt           = fallback_c;
            attempt_nxt            = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and stored speed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_rpm_r  <= '0;
      attempt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_rpm_r  <= last_rpm_nxt;
      attempt_r   <= attempt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-transaction flags and output payload.
  always_ff @(posedge clk) begin
    gated_r    <= gated_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= '0;
      drive1_r <= '0;
      drive2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TACH_CAP:   cap_r    <= cfg_wdata[CAP_W-1:0];
        CFG_FAN1_DRIVE: drive1_r <= cfg_wdata;
        CFG_FAN2_DRIVE: drive2_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/ftach_div.sv]
// Restoring divider that divides the per-minute constant by a divisor, one bit per cycle.
module ftach_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ftach_pkg::DIVR_W-1:0] divisor,
  output logic                       done,
  output logic [ftach_pkg::QUO_W-1:0]  quotient
);
  import ftach_pkg::*;

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [DIVR_W-1:0] dvsr_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVR_W-1:0] rem_nxt;
  logic [QUO_W-1:0]  quo_r;
  logic [DIVR_W:0]   shift_c;
  logic [DIVR_W:0]   diff_c;
  logic              ge_c;

  // One restoring step: bring down the next dividend bit and try to subtract.
  always_comb begin
    shift_c = {rem_r, US_PER_MINUTE[step_r]};
    diff_c  = shift_c - {1'b0, dvsr_r};
    ge_c    = (shift_c >= {1'b0, dvsr_r});
    rem_nxt = ge_c ? diff_c[DIVR_W-1:0] : shift_c[DIVR_W-1:0];
  end

  // The last step is the one with the lowest dividend bit.
  assign done     = busy_r && (step_r == '0);
  assign quotient = quo_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= STEP_W'(QUO_W - 1);
    end else if (busy_r) begin
      busy_r <= (step_r != '0);
      step_r <= step_r - 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvsr_r <= divisor;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[QUO_W-2:0], ge_c};
    end
  end

endmodule

[rtl/ftach_chk.sv]
// Port-level checker for the fan tachometer speed debouncer, bound to the top level.
module ftach_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input ftach_pkg::out_data_t out_data
);
  import ftach_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted sample keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block ready right after accepting a sample");

  // A settled result is always below the acceptance ceiling.
  a_settled_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.settled |-> out_data.rpm_value < ACCEPT_CEILING)
    else $error("settled speed out of range");

  // A fallback or gated result never exceeds the fallback ceiling.
  a_fallback_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.settled |-> out_data.rpm_value <= FALLBACK_CEILING)
    else $error("fallback speed out of range");

endmodule

bind fan_tach_rpm_debouncer_top ftach_chk u_ftach_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
